// ===== hw/rtl/mtns_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI track note segmenter package
// Shared types, constants and result codes for the segmenter block.
// ----------------------------------------------------------------------------
package mtns_pkg;

    // Parse phases of the byte parser.
    typedef enum logic [4:0] {
        PH_HUNT   = 5'd0,
        PH_TAG1   = 5'd1,
        PH_TAG2   = 5'd2,
        PH_TAG3H  = 5'd3,
        PH_TAG3T  = 5'd4,
        PH_HLEN   = 5'd5,
        PH_HFIELD = 5'd6,
        PH_TLEN   = 5'd7,
        PH_CSKIP  = 5'd8,
        PH_DELTA  = 5'd9,
        PH_STATUS = 5'd10,
        PH_DATA1  = 5'd11,
        PH_DATA2  = 5'd12,
        PH_MTYPE  = 5'd13,
        PH_MLEN   = 5'd14,
        PH_MDATA  = 5'd15,
        PH_XLEN   = 5'd16,
        PH_XDATA  = 5'd17
    } phase_t;

    // Controller states.
    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_DIV  = 2'd1,
        CS_OUT  = 2'd2
    } ctrl_state_t;

    // Result kinds.
    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_TEMPO  = 3'd1;
    localparam logic [2:0] KIND_REST   = 3'd2;
    localparam logic [2:0] KIND_NOTE   = 3'd3;
    localparam logic [2:0] KIND_TEND   = 3'd4;

    localparam logic [7:0] BYTE_M      = 8'h4D;
    localparam logic [7:0] BYTE_H      = 8'h68;
    localparam logic [7:0] BYTE_R      = 8'h72;
    localparam logic [7:0] BYTE_META   = 8'hFF;
    localparam logic [7:0] BYTE_SYSEX  = 8'hF0;
    localparam logic [7:0] BYTE_ESCAPE = 8'hF7;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] REST_NOTE   = 8'd128;
    localparam logic [25:0] BPM_NUMER  = 26'd60000000;
    localparam int DIV_STEPS           = 26;

    // One result item.
    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] track_number;
        logic [31:0] at_tick;
        logic [7:0]  note_number;
        logic [31:0] duration_ticks;
        logic [25:0] beats_per_minute;
        logic [15:0] midi_format;
        logic [15:0] track_count;
        logic [15:0] ticks_per_quarter;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_byte;
        logic div_start;
        logic div_step;
        logic load_bpm;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;
        logic tempo;
        logic div_last;
    } dp_stat_t;

endpackage

// ===== hw/rtl/mtns_if.sv =====
// ----------------------------------------------------------------------------
// Byte stream channel interface
// Valid/ready channel carrying one input file byte and a file start mark.
// ----------------------------------------------------------------------------
interface mtns_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;

    modport source (output valid, output data_byte, output file_start, input ready);
    modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface mtns_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [15:0] track_number;
    logic [31:0] at_tick;
    logic [7:0]  note_number;
    logic [31:0] duration_ticks;
    logic [25:0] beats_per_minute;
    logic [15:0] midi_format;
    logic [15:0] track_count;
    logic [15:0] ticks_per_quarter;

    modport source (output valid, output result_kind, output track_number, output at_tick,
        output note_number, output duration_ticks, output beats_per_minute,
        output midi_format, output track_count, output ticks_per_quarter, input ready);
    modport sink (input valid, input result_kind, input track_number, input at_tick,
        input note_number, input duration_ticks, input beats_per_minute,
        input midi_format, input track_count, input ticks_per_quarter, output ready);
endinterface

// ----------------------------------------------------------------------------
// Configuration write channel interface
// Valid/ready channel carrying the tracked note channel.
// ----------------------------------------------------------------------------
interface mtns_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mtns_ctrl.sv =====
// ----------------------------------------------------------------------------
// Segmenter controller
// Sequences byte intake, the tempo division and result hand-off.
// ----------------------------------------------------------------------------
module mtns_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_busy,
    input  logic               out_take,
    output logic               out_load,
    output mtns_pkg::dp_cmd_t  cmd,
    input  mtns_pkg::dp_stat_t stat
);

    mtns_pkg::ctrl_state_t state_reg;
    mtns_pkg::ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtns_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. A byte is taken only when the output
    // register can hold whatever it may produce.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            mtns_pkg::CS_IDLE:
            begin
                in_ready      = !out_busy || out_take;
                cmd.take_byte = in_valid && in_ready;
                if (cmd.take_byte && stat.emit)
                begin
                    if (stat.tempo)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = mtns_pkg::CS_DIV;
                    end
                    else
                    begin
                        out_load = 1'b1;
                    end
                end
            end
            mtns_pkg::CS_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = mtns_pkg::CS_OUT;
                end
            end
            mtns_pkg::CS_OUT:
            begin
                if (!out_busy || out_take)
                begin
                    cmd.load_bpm = 1'b1;
                    out_load     = 1'b1;
                    state_next   = mtns_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = mtns_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/mtns_dp.sv =====
// ----------------------------------------------------------------------------
// Segmenter datapath
// Parse state, header latches, note tracking and the restoring tempo divider.
// ----------------------------------------------------------------------------
module mtns_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  logic               file_start,
    input  logic [3:0]         note_channel,
    input  mtns_pkg::dp_cmd_t  cmd,
    output mtns_pkg::dp_stat_t stat,
    output mtns_pkg::result_t  result
);

    mtns_pkg::phase_t phase_reg, phase_next;
    logic [31:0] shift_reg, shift_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic [31:0] tleft_reg, tleft_next;
    logic [31:0] tick_reg, tick_next;
    logic [27:0] dacc_reg, dacc_next;
    logic        rna_reg, rna_next;
    logic [7:0]  held_reg, held_next;
    logic [31:0] chord_reg, chord_next;
    logic [31:0] sil_reg, sil_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [31:0] mleft_reg, mleft_next;
    logic [15:0] tidx_reg, tidx_next;
    logic [7:0]  rstat_reg, rstat_next;
    logic [7:0]  key_reg, key_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] trk_reg, trk_next;
    logic [15:0] div_reg, div_next;

    // Divider registers.
    logic [23:0] dvs_reg;
    logic [25:0] quo_reg;
    logic [24:0] rem_reg;
    logic [4:0]  dcnt_reg;
    logic        dzero_reg;

    mtns_pkg::result_t res;
    logic              emit;
    logic              is_tempo;

    // Parse view after an optional file start clear.
    mtns_pkg::phase_t ph;
    logic [31:0] sh, tl, tk, cs, ss, ml;
    logic [27:0] da;
    logic [2:0]  fc;
    logic        ra;
    logic [7:0]  hn, mt, rs, ky;
    logic [15:0] ti, hf, ht, hd;
    logic [27:0] vlq_d, vlq_f;
    logic [2:0]  fc_inc;
    logic        vlq_done;
    logic [7:0]  b7;
    logic [31:0] ml_dec;

    assign b7 = {1'b0, data_byte[6:0]};

    always_comb
    begin
        ph = file_start ? mtns_pkg::PH_HUNT : phase_reg;
        sh = file_start ? '0 : shift_reg;
        fc = file_start ? '0 : fcnt_reg;
        tl = file_start ? '0 : tleft_reg;
        tk = file_start ? '0 : tick_reg;
        da = file_start ? '0 : dacc_reg;
        ra = file_start ? '0 : rna_reg;
        hn = file_start ? '0 : held_reg;
        cs = file_start ? '0 : chord_reg;
        ss = file_start ? '0 : sil_reg;
        mt = file_start ? '0 : mtype_reg;
        ml = file_start ? '0 : mleft_reg;
        ti = file_start ? '0 : tidx_reg;
        rs = file_start ? '0 : rstat_reg;
        ky = file_start ? '0 : key_reg;
        hf = file_start ? '0 : fmt_reg;
        ht = file_start ? '0 : trk_reg;
        hd = file_start ? '0 : div_reg;

        fc_inc   = fc + 3'd1;
        vlq_done = !data_byte[7] || (fc_inc >= 3'd4);
        vlq_d    = {da[20:0], data_byte[6:0]};
        vlq_f    = {sh[20:0], data_byte[6:0]};
        ml_dec   = (ml != 32'd0) ? ml - 32'd1 : ml;
    end

    // Next parse state and the result, if any.
    always_comb
    begin
        phase_next = ph;
        shift_next = sh;  fcnt_next = fc;  tleft_next = tl;
        tick_next = tk;   dacc_next = da;  rna_next = ra;
        held_next = hn;   chord_next = cs; sil_next = ss;
        mtype_next = mt;  mleft_next = ml; tidx_next = ti;
        rstat_next = rs;  key_next = ky;
        fmt_next = hf;    trk_next = ht;   div_next = hd;
        emit = 1'b0;
        is_tempo = 1'b0;
        res = '0;

        if (ph >= mtns_pkg::PH_CSKIP && tl == 32'd0)
        begin
            // Chunk exhausted: close the track unless skipping, and hunt for a tag.
            if (ph != mtns_pkg::PH_CSKIP)
            begin
                emit = 1'b1;
                res.result_kind = mtns_pkg::KIND_TEND;
                res.at_tick = tk;
                tidx_next = ti + 16'd1;
            end
            phase_next = (data_byte == mtns_pkg::BYTE_M) ? mtns_pkg::PH_TAG1
                                                         : mtns_pkg::PH_HUNT;
        end
        else
        begin
            if (ph >= mtns_pkg::PH_CSKIP)
            begin
                tleft_next = tl - 32'd1;
            end
            unique case (ph)
                mtns_pkg::PH_HUNT:
                begin
                    phase_next = (data_byte == mtns_pkg::BYTE_M) ? mtns_pkg::PH_TAG1
                                                                 : mtns_pkg::PH_HUNT;
                end
                mtns_pkg::PH_TAG1:
                begin
                    phase_next = mtns_pkg::PH_TAG2;
                end
                mtns_pkg::PH_TAG2:
                begin
                    if (data_byte == mtns_pkg::BYTE_H)
                        phase_next = mtns_pkg::PH_TAG3H;
                    else if (data_byte == mtns_pkg::BYTE_R)
                        phase_next = mtns_pkg::PH_TAG3T;
                    else if (data_byte == mtns_pkg::BYTE_M)
                        phase_next = mtns_pkg::PH_TAG1;
                    else
                        phase_next = mtns_pkg::PH_HUNT;
                end
                mtns_pkg::PH_TAG3H, mtns_pkg::PH_TAG3T:
                begin
                    phase_next = (ph == mtns_pkg::PH_TAG3H) ? mtns_pkg::PH_HLEN
                                                            : mtns_pkg::PH_TLEN;
                    shift_next = '0;
                    fcnt_next  = '0;
                end
                mtns_pkg::PH_HLEN, mtns_pkg::PH_TLEN:
                begin
                    shift_next = {sh[23:0], data_byte};
                    fcnt_next  = fc_inc;
                    if (fc_inc >= 3'd4)
                    begin
                        tleft_next = {sh[23:0], data_byte};
                        shift_next = '0;
                        fcnt_next  = '0;
                        if (ph == mtns_pkg::PH_HLEN)
                        begin
                            phase_next = mtns_pkg::PH_HFIELD;
                        end
                        else
                        begin
                            tick_next = '0;  dacc_next = '0; held_next = '0;
                            chord_next = '0; sil_next = '0;  rstat_next = '0;
                            rna_next = 1'b0;
                            phase_next = mtns_pkg::PH_DELTA;
                        end
                    end
                end
                mtns_pkg::PH_HFIELD:
                begin
                    if (tl != 32'd0)
                        tleft_next = tl - 32'd1;
                    unique case (fc)
                        3'd0: fmt_next = {data_byte, 8'd0};
                        3'd1: fmt_next = {hf[15:8], hf[7:0] | data_byte};
                        3'd2: trk_next = {data_byte, 8'd0};
                        3'd3: trk_next = {ht[15:8], ht[7:0] | data_byte};
                        3'd4: div_next = {data_byte, 8'd0};
                        default: div_next = {hd[15:8], hd[7:0] | data_byte};
                    endcase
                    fcnt_next = fc_inc;
                    if (fc_inc >= 3'd6)
                    begin
                        fcnt_next  = '0;
                        phase_next = mtns_pkg::PH_CSKIP;
                        emit = 1'b1;
                        res.result_kind = mtns_pkg::KIND_HEADER;
                    end
                end
                mtns_pkg::PH_CSKIP:
                begin
                end
                mtns_pkg::PH_DELTA:
                begin
                    dacc_next = vlq_d;
                    fcnt_next = fc_inc;
                    if (vlq_done)
                    begin
                        fcnt_next  = '0;
                        tick_next  = tk + {4'd0, vlq_d};
                        dacc_next  = '0;
                        phase_next = mtns_pkg::PH_STATUS;
                    end
                end
                mtns_pkg::PH_STATUS, mtns_pkg::PH_DATA1:
                begin
                    if (ph == mtns_pkg::PH_DATA1 ||
                        (data_byte < 8'h80 && rs != 8'd0))
                    begin
                        key_next = b7;
                        phase_next = (rs[7:4] == 4'hC || rs[7:4] == 4'hD)
                                     ? mtns_pkg::PH_DELTA : mtns_pkg::PH_DATA2;
                    end
                    else if (data_byte == mtns_pkg::BYTE_META)
                    begin
                        rstat_next = '0; rna_next = 1'b0;
                        phase_next = mtns_pkg::PH_MTYPE;
                    end
                    else if (data_byte == mtns_pkg::BYTE_SYSEX ||
                             data_byte == mtns_pkg::BYTE_ESCAPE)
                    begin
                        rstat_next = '0; rna_next = 1'b0;
                        shift_next = '0; fcnt_next = '0;
                        phase_next = mtns_pkg::PH_XLEN;
                    end
                    else if (data_byte > mtns_pkg::BYTE_SYSEX)
                    begin
                        rstat_next = '0; rna_next = 1'b0;
                        phase_next = mtns_pkg::PH_DELTA;
                    end
                    else if (data_byte[7])
                    begin
                        rstat_next = data_byte;
                        rna_next   = (data_byte[7:5] == 3'b100) &&
                                     (data_byte[3:0] == note_channel);
                        phase_next = mtns_pkg::PH_DATA1;
                    end
                    else
                    begin
                        phase_next = mtns_pkg::PH_DELTA;
                    end
                end
                mtns_pkg::PH_DATA2:
                begin
                    phase_next = mtns_pkg::PH_DELTA;
                    if (ra)
                    begin
                        if (rs[7:4] == 4'h9 && data_byte[6:0] != 7'd0)
                        begin
                            if (hn == 8'd0)
                            begin
                                emit = 1'b1;
                                res.result_kind    = mtns_pkg::KIND_REST;
                                res.at_tick        = tk;
                                res.note_number    = mtns_pkg::REST_NOTE;
                                res.duration_ticks = tk - ss;
                                chord_next = tk;
                            end
                            if (hn != 8'hFF)
                                held_next = hn + 8'd1;
                        end
                        else if (hn != 8'd0)
                        begin
                            held_next = hn - 8'd1;
                            if (hn == 8'd1)
                            begin
                                emit = 1'b1;
                                res.result_kind    = mtns_pkg::KIND_NOTE;
                                res.at_tick        = tk;
                                res.note_number    = ky;
                                res.duration_ticks = tk - cs;
                                sil_next = tk;
                            end
                        end
                    end
                end
                mtns_pkg::PH_MTYPE:
                begin
                    mtype_next = data_byte;
                    shift_next = '0;
                    fcnt_next  = '0;
                    phase_next = mtns_pkg::PH_MLEN;
                end
                mtns_pkg::PH_MLEN, mtns_pkg::PH_XLEN:
                begin
                    shift_next = {4'd0, vlq_f};
                    fcnt_next  = fc_inc;
                    if (vlq_done)
                    begin
                        fcnt_next  = '0;
                        mleft_next = {4'd0, vlq_f};
                        shift_next = '0;
                        if (ph == mtns_pkg::PH_XLEN)
                        begin
                            phase_next = (vlq_f == 28'd0) ? mtns_pkg::PH_DELTA
                                                          : mtns_pkg::PH_XDATA;
                        end
                        else if (vlq_f != 28'd0)
                        begin
                            phase_next = mtns_pkg::PH_MDATA;
                        end
                        else if (mt == mtns_pkg::META_TEMPO)
                        begin
                            emit = 1'b1; is_tempo = 1'b1;
                            res.result_kind = mtns_pkg::KIND_TEMPO;
                            res.at_tick = tk;
                            phase_next = mtns_pkg::PH_DELTA;
                        end
                        else if (mt == mtns_pkg::META_EOT)
                        begin
                            emit = 1'b1;
                            res.result_kind = mtns_pkg::KIND_TEND;
                            res.at_tick = tk;
                            tidx_next = ti + 16'd1;
                            phase_next = mtns_pkg::PH_CSKIP;
                        end
                        else
                        begin
                            phase_next = mtns_pkg::PH_DELTA;
                        end
                    end
                end
                mtns_pkg::PH_MDATA:
                begin
                    if (mt == mtns_pkg::META_TEMPO && fc < 3'd3)
                    begin
                        shift_next = {sh[23:0], data_byte};
                        fcnt_next  = fc_inc;
                    end
                    mleft_next = ml_dec;
                    if (ml_dec == 32'd0)
                    begin
                        fcnt_next = '0;
                        if (mt == mtns_pkg::META_TEMPO)
                        begin
                            emit = 1'b1; is_tempo = 1'b1;
                            res.result_kind = mtns_pkg::KIND_TEMPO;
                            res.at_tick = tk;
                            phase_next = mtns_pkg::PH_DELTA;
                        end
                        else if (mt == mtns_pkg::META_EOT)
                        begin
                            emit = 1'b1;
                            res.result_kind = mtns_pkg::KIND_TEND;
                            res.at_tick = tk;
                            tidx_next = ti + 16'd1;
                            phase_next = mtns_pkg::PH_CSKIP;
                        end
                        else
                        begin
                            phase_next = mtns_pkg::PH_DELTA;
                        end
                    end
                end
                mtns_pkg::PH_XDATA:
                begin
                    mleft_next = ml_dec;
                    if (ml_dec == 32'd0)
                        phase_next = mtns_pkg::PH_DELTA;
                end
                default:
                begin
                    phase_next = mtns_pkg::PH_HUNT;
                end
            endcase
        end
        res.track_number      = ti;
        res.midi_format       = fmt_next;
        res.track_count       = trk_next;
        res.ticks_per_quarter = div_next;
    end

    assign stat.emit  = emit;
    assign stat.tempo = is_tempo;
    assign stat.div_last = (dcnt_reg == 5'd0);

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mtns_pkg::PH_HUNT;
            shift_reg <= '0; fcnt_reg <= '0; tleft_reg <= '0; tick_reg <= '0;
            dacc_reg <= '0;  rna_reg <= 1'b0; held_reg <= '0; chord_reg <= '0;
            sil_reg <= '0;   mtype_reg <= '0; mleft_reg <= '0; tidx_reg <= '0;
            rstat_reg <= '0; key_reg <= '0;   fmt_reg <= '0;   trk_reg <= '0;
            div_reg <= '0;
        end
        else if (cmd.take_byte)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next; fcnt_reg <= fcnt_next; tleft_reg <= tleft_next;
            tick_reg <= tick_next;   dacc_reg <= dacc_next; rna_reg <= rna_next;
            held_reg <= held_next;   chord_reg <= chord_next; sil_reg <= sil_next;
            mtype_reg <= mtype_next; mleft_reg <= mleft_next; tidx_reg <= tidx_next;
            rstat_reg <= rstat_next; key_reg <= key_next; fmt_reg <= fmt_next;
            trk_reg <= trk_next;     div_reg <= div_next;
        end
    end

    // Restoring divider: one quotient bit per cycle of 60000000 / tempo.
    logic [24:0] rem_try;
    logic [25:0] rem_sh;
    logic [4:0]  bit_idx;

    always_comb
    begin
        bit_idx = dcnt_reg;
        rem_sh  = {rem_reg, mtns_pkg::BPM_NUMER[bit_idx]};
        rem_try = rem_sh[24:0] - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= 5'(mtns_pkg::DIV_STEPS - 1);
        end
        else if (cmd.div_step && dcnt_reg != 5'd0)
        begin
            dcnt_reg <= dcnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvs_reg   <= shift_next[23:0];
            dzero_reg <= (shift_next[23:0] == 24'd0);
            rem_reg   <= '0;
            quo_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {2'b0, dvs_reg})
            begin
                rem_reg <= rem_try;
                quo_reg <= {quo_reg[24:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[24:0];
                quo_reg <= {quo_reg[24:0], 1'b0};
            end
        end
    end

    // Pending result held across the division.
    mtns_pkg::result_t pend_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && emit)
        begin
            pend_reg <= res;
        end
    end

    always_comb
    begin
        if (cmd.load_bpm)
        begin
            result = pend_reg;
            result.beats_per_minute = dzero_reg ? 26'd0 : quo_reg;
        end
        else
        begin
            result = res;
        end
    end

endmodule

// ===== hw/rtl/midi_track_note_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// MIDI track note segmenter
// Parses a Standard MIDI File byte stream into header, tempo, rest, note and
// track end results.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on in_ch (valid/ready); file_start marks the first byte of a
// file and clears all parse state. Results leave on out_ch, at most one per
// byte, from an output register. The note channel is to be written on cfg_ch
// only while the block is idle; the block itself does not enforce this.
// A result appears on out_ch in the cycle after the byte that causes it is
// taken. A tempo result first runs the restoring divider and then waits in a
// hand-off state until the output register can take it; no byte is accepted.
// Throughput: one byte per cycle, but for the divider and the stall below.
// Reset: all parse state and the note channel clear; no result is pending.
// Stall: while a result waits in the output register, a byte is still taken
// if the register is emptied in the same cycle; otherwise in_ch waits.
// ----------------------------------------------------------------------------
module midi_track_note_segmenter_unit (
    input logic          clk,
    input logic          rst_n,
    mtns_in_if.sink      in_ch,
    mtns_out_if.source   out_ch,
    mtns_cfg_if.sink     cfg_ch
);

    logic [3:0]         chan_reg;
    mtns_pkg::dp_cmd_t  cmd;
    mtns_pkg::dp_stat_t stat;
    mtns_pkg::result_t  result;
    mtns_pkg::result_t  out_reg;
    logic               ov_reg;
    logic               out_load;
    logic               out_take;

    assign cfg_ch.ready = 1'b1;

    // Note channel register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chan_reg <= '0;
        else if (cfg_ch.valid)
            chan_reg <= cfg_ch.data;
    end

    assign out_take = ov_reg && out_ch.ready;

    mtns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_busy (ov_reg),
        .out_take (out_take),
        .out_load (out_load),
        .cmd      (cmd),
        .stat     (stat)
    );

    mtns_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (in_ch.data_byte),
        .file_start   (in_ch.file_start),
        .note_channel (chan_reg),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (out_load)
            ov_reg <= 1'b1;
        else if (out_take)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= result;
    end

    assign out_ch.valid             = ov_reg;
    assign out_ch.result_kind       = out_reg.result_kind;
    assign out_ch.track_number      = out_reg.track_number;
    assign out_ch.at_tick           = out_reg.at_tick;
    assign out_ch.note_number       = out_reg.note_number;
    assign out_ch.duration_ticks    = out_reg.duration_ticks;
    assign out_ch.beats_per_minute  = out_reg.beats_per_minute;
    assign out_ch.midi_format       = out_reg.midi_format;
    assign out_ch.track_count       = out_reg.track_count;
    assign out_ch.ticks_per_quarter = out_reg.ticks_per_quarter;

    // A new result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!ov_reg || out_take))
        else $error("result register overwritten");

    // No byte is taken while the divider runs.
    a_div_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !in_ch.ready)
        else $error("byte accepted during division");

    // Result kinds stay within their defined codes.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (out_reg.result_kind <= mtns_pkg::KIND_TEND))
        else $error("bad result kind");

endmodule
